@@ hdl/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and the search stage record for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_FRAC  = 14;
    localparam int EDGE_W    = IN_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W;
    localparam int R_SHIFT   = 2 * (OUT_FRAC + 1);
    localparam int RS_W      = SQ_W + R_SHIFT + 1;
    localparam int N_W       = OUT_FRAC + 1;
    localparam int D_W       = SUM_W + 2 * N_W;
    localparam int G_W       = SUM_W + N_W + 2;
    localparam int CMP_W     = D_W + 3;
    localparam int N_STAGES  = N_W;

    typedef struct packed {
        logic [SUM_W-1:0]          s;
        logic [2:0][RS_W-1:0]      rs;
        logic [2:0][D_W-1:0]       d;
        logic [2:0][G_W-1:0]       g;
        logic [2:0][N_W-1:0]       n;
        logic [2:0]                neg;
        logic                      deg;
    } srch_t;

endpackage

@@ hdl/triangle_face_normal_top.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Unit face normal of a triangle, Q2.14 vertices in, Q2.14 normal out.
// ----------------------------------------------------------------------------
// Channel   Handshake       Payload
// input     start / busy    a_x a_y a_z b_x b_y b_z c_x c_y c_z
// result    done            normal_x normal_y normal_z degenerate
//
// One item enters per cycle.
// Five stages form edges, products, cross, squares and the sum of squares,
// then fifteen stages resolve one normal bit each, and one stage applies signs.
// Reset clears only the valid bits. Busy stays low since nothing stalls.
// ----------------------------------------------------------------------------
module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] a_x,
    input  logic signed [IN_W-1:0] a_y,
    input  logic signed [IN_W-1:0] a_z,
    input  logic signed [IN_W-1:0] b_x,
    input  logic signed [IN_W-1:0] b_y,
    input  logic signed [IN_W-1:0] b_z,
    input  logic signed [IN_W-1:0] c_x,
    input  logic signed [IN_W-1:0] c_y,
    input  logic signed [IN_W-1:0] c_z,
    output logic                   done,
    output logic signed [IN_W-1:0] normal_x,
    output logic signed [IN_W-1:0] normal_y,
    output logic signed [IN_W-1:0] normal_z,
    output logic                   degenerate
);

    logic [4:0]                v_reg;
    logic                      done_reg;
    logic signed [EDGE_W-1:0]  u_reg [3];
    logic signed [EDGE_W-1:0]  w_reg [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] cr [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [2:0]                neg_reg;
    logic [2:0]                neg2_reg;
    logic [SQ_W-1:0]           sq_reg [3];
    logic [SUM_W+1:0]          ssum;
    srch_t                     st0_reg;
    srch_t                     st0_next;
    srch_t                     st [N_STAGES+1];
    logic                      sv [N_STAGES+1];
    logic [IN_W-1:0]           nv [3];
    logic [IN_W-1:0]           res_next [3];
    logic [IN_W-1:0]           res_reg [3];
    logic                      deg_reg;
    logic                      accept;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[3:0], accept};
            done_reg <= sv[N_STAGES];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr[i] = CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
        end
        ssum = (SUM_W+2)'(sq_reg[0]) + (SUM_W+2)'(sq_reg[1]) + (SUM_W+2)'(sq_reg[2]);
        st0_next.s   = ssum[SUM_W-1:0];
        st0_next.neg = neg2_reg;
        st0_next.deg = (ssum == '0);
        for (int i = 0; i < 3; i++)
        begin
            st0_next.rs[i] = RS_W'({sq_reg[i], {R_SHIFT{1'b0}}}) - RS_W'(ssum[SUM_W-1:0]);
            st0_next.d[i]  = '0;
            st0_next.g[i]  = G_W'(0) - {{(G_W-SUM_W){1'b0}}, ssum[SUM_W-1:0]};
            st0_next.n[i]  = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = {{(IN_W-N_W){1'b0}}, st[N_STAGES].n[i]};
            if (st[N_STAGES].deg)
            begin
                res_next[i] = '0;
            end
            else if (st[N_STAGES].neg[i])
            begin
                res_next[i] = IN_W'(0) - nv[i];
            end
            else
            begin
                res_next[i] = nv[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg[0] <= {a_x[IN_W-1], a_x} - {b_x[IN_W-1], b_x};
        u_reg[1] <= {a_y[IN_W-1], a_y} - {b_y[IN_W-1], b_y};
        u_reg[2] <= {a_z[IN_W-1], a_z} - {b_z[IN_W-1], b_z};
        w_reg[0] <= {b_x[IN_W-1], b_x} - {c_x[IN_W-1], c_x};
        w_reg[1] <= {b_y[IN_W-1], b_y} - {c_y[IN_W-1], c_y};
        w_reg[2] <= {b_z[IN_W-1], b_z} - {c_z[IN_W-1], c_z};
        p_reg[0] <= u_reg[1] * w_reg[2];
        p_reg[1] <= w_reg[1] * u_reg[2];
        p_reg[2] <= u_reg[2] * w_reg[0];
        p_reg[3] <= w_reg[2] * u_reg[0];
        p_reg[4] <= u_reg[0] * w_reg[1];
        p_reg[5] <= w_reg[0] * u_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            neg_reg[i] <= cr[i][CROSS_W-1];
            mag_reg[i] <= cr[i][CROSS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
            sq_reg[i]  <= mag_reg[i] * mag_reg[i];
            res_reg[i] <= res_next[i];
        end
        neg2_reg <= neg_reg;
        st0_reg  <= st0_next;
        deg_reg  <= st[N_STAGES].deg;
    end

    assign st[0] = st0_reg;
    assign sv[0] = v_reg[4];

    for (genvar j = 0; j < N_STAGES; j++)
    begin : g_search
        tfn_step #(
            .K (N_STAGES - 1 - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sv[j]),
            .in_st     (st[j]),
            .out_valid (sv[j+1]),
            .out_st    (st[j+1])
        );
    end

    assign done       = done_reg;
    assign normal_x   = res_reg[0];
    assign normal_y   = res_reg[1];
    assign normal_z   = res_reg[2];
    assign degenerate = deg_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##21 done)
        else $error("result strobe missing after pipeline latency");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("degenerate result carries a nonzero normal");

    a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> !(normal_x == 0 && normal_y == 0 && normal_z == 0))
        else $error("regular triangle gave a zero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> normal_x >= -16384 && normal_x <= 16384
              && normal_y >= -16384 && normal_y <= 16384
              && normal_z >= -16384 && normal_z <= 16384)
        else $error("normal component out of unit range");
`endif

endmodule

@@ hdl/tfn_step.sv @@
// ----------------------------------------------------------------------------
// tfn_step
// One bit of the rounded normalization search for all three components.
// ----------------------------------------------------------------------------
module tfn_step
    import tfn_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  srch_t in_st,
    output logic  out_valid,
    output srch_t out_st
);

    localparam logic [N_W-1:0] BIT = N_W'(1) << K;

    logic               valid_reg;
    srch_t              st_reg;
    srch_t              st_next;
    logic signed [CMP_W-1:0] tt [3];
    logic signed [CMP_W-1:0] rs_ext [3];
    logic [2:0]         ok;

    always_comb
    begin
        st_next = in_st;
        for (int i = 0; i < 3; i++)
        begin
            tt[i] = $signed({{(CMP_W-D_W){1'b0}}, in_st.d[i]})
                + ($signed({{(CMP_W-G_W){in_st.g[i][G_W-1]}}, in_st.g[i]}) <<< K)
                + ($signed({{(CMP_W-SUM_W){1'b0}}, in_st.s}) <<< (2 * K));
            rs_ext[i] = $signed({{(CMP_W-RS_W){in_st.rs[i][RS_W-1]}}, in_st.rs[i]});
            ok[i] = (tt[i] <<< 2) <= rs_ext[i];
            if (ok[i])
            begin
                st_next.n[i] = in_st.n[i] | BIT;
                st_next.d[i] = tt[i][D_W-1:0];
                st_next.g[i] = in_st.g[i]
                    + ({{(G_W-SUM_W){1'b0}}, in_st.s} << (K + 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

@@ sim/triangle_face_normal_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_face_normal_checker
// Predicts the unit face normal of each accepted triangle and compares it
// with each result strobed on done, in order, field by field.
// ----------------------------------------------------------------------------
module triangle_face_normal_checker
    import tfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic signed [IN_W-1:0] a_x,
    input  logic signed [IN_W-1:0] a_y,
    input  logic signed [IN_W-1:0] a_z,
    input  logic signed [IN_W-1:0] b_x,
    input  logic signed [IN_W-1:0] b_y,
    input  logic signed [IN_W-1:0] b_z,
    input  logic signed [IN_W-1:0] c_x,
    input  logic signed [IN_W-1:0] c_y,
    input  logic signed [IN_W-1:0] c_z,
    input  logic                   done,
    input  logic signed [IN_W-1:0] normal_x,
    input  logic signed [IN_W-1:0] normal_y,
    input  logic signed [IN_W-1:0] normal_z,
    input  logic                   degenerate,
    output int                     fail_count,
    output int                     pending,
    output int                     degenerate_seen,
    output int                     normals_seen
);

    typedef struct packed {
        logic signed [IN_W-1:0] nx;
        logic signed [IN_W-1:0] ny;
        logic signed [IN_W-1:0] nz;
        logic                   deg;
    } normal_t;

    normal_t expected_normals[$];

    function automatic logic [15:0] unit_component(input logic signed [63:0] c,
                                                   input logic [127:0] sum_sq);
        logic [63:0]  mag;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  t;
        mag = (c < 0) ? -c : c;
        rhs = (128'(2 * 16384) * mag) * (128'(2 * 16384) * mag);
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            lhs = sum_sq * (t * t);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (c < 0)
            lo = -lo;
        return lo[15:0];
    endfunction

    function automatic normal_t face_normal();
        logic signed [63:0] ux, uy, uz, vx, vy, vz, cx_, cy_, cz_;
        logic [127:0]       sum_sq;
        normal_t            r;
        ux = 64'(a_x) - 64'(b_x);
        uy = 64'(a_y) - 64'(b_y);
        uz = 64'(a_z) - 64'(b_z);
        vx = 64'(b_x) - 64'(c_x);
        vy = 64'(b_y) - 64'(c_y);
        vz = 64'(b_z) - 64'(c_z);
        cx_ = uy * vz - vy * uz;
        cy_ = uz * vx - vz * ux;
        cz_ = ux * vy - vx * uy;
        sum_sq = 128'(cx_) * 128'(cx_) + 128'(cy_) * 128'(cy_) + 128'(cz_) * 128'(cz_);
        if (sum_sq == 0)
        begin
            r = '{nx: 0, ny: 0, nz: 0, deg: 1'b1};
        end
        else
        begin
            r.nx = unit_component(cx_, sum_sq);
            r.ny = unit_component(cy_, sum_sq);
            r.nz = unit_component(cz_, sum_sq);
            r.deg = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        degenerate_seen = 0;
        normals_seen = 0;
    end

    always @(posedge clk)
    begin
        normal_t got;
        normal_t want;
        if (rst_n)
        begin
            if (start && !busy)
                expected_normals.push_back(face_normal());
            if (done)
            begin
                got = '{nx: normal_x, ny: normal_y, nz: normal_z, deg: degenerate};
                if (expected_normals.size() == 0)
                begin
                    report_mismatch("result with no item outstanding");
                end
                else
                begin
                    want = expected_normals.pop_front();
                    normals_seen++;
                    if (want.deg)
                        degenerate_seen++;
                    if (got.nx !== want.nx)
                        report_mismatch($sformatf("normal_x %0d, want %0d", got.nx, want.nx));
                    if (got.ny !== want.ny)
                        report_mismatch($sformatf("normal_y %0d, want %0d", got.ny, want.ny));
                    if (got.nz !== want.nz)
                        report_mismatch($sformatf("normal_z %0d, want %0d", got.nz, want.nz));
                    if (got.deg !== want.deg)
                        report_mismatch($sformatf("degenerate %0b, want %0b",
                                                  got.deg, want.deg));
                end
            end
            pending <= expected_normals.size();
        end
    end

endmodule

@@ sim/tb_triangle_face_normal_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_top
// Drives directed and random triangles through the face normal pipeline
// with varying input gaps; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_top
    import tfn_pkg::*;
();

    localparam int PIPE_LATENCY = 21;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [IN_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic done;
    logic signed [IN_W-1:0] normal_x, normal_y, normal_z;
    logic degenerate;
    int   fail_count;
    int   pending;
    int   degenerate_seen;
    int   normals_seen;
    int   idle_pct;

    triangle_face_normal_top i_dut (.*);

    triangle_face_normal_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("triangle_face_normal_top regression: fail");
        $finish;
    end

    task automatic send_triangle(input logic [8:0][15:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [8:0][15:0] v;
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 9; k++)
                v[k] = rand_coord();
            case ($urandom_range(9))
                0: v[5:3] = v[8:6];
                1: v[2:0] = v[5:3];
                2: v[8:6] = v[2:0];
                default: ;
            endcase
            send_triangle(v);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || start)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] p;
        logic [15:0] m;
        rst_n = 1'b0;
        start = 1'b0;
        idle_pct = 0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        p = 16'h7fff;
        m = 16'h8000;
        send_triangle({9{16'h0000}});
        send_triangle({9{p}});
        send_triangle({9{m}});
        send_triangle({p, p, p, m, m, m, p, m, p});
        send_triangle({p, m, m, m, p, m, m, m, p});
        send_triangle({m, p, p, p, m, p, p, p, m});
        send_triangle({16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0,
                       16'd0, 16'd0, 16'd16384});
        send_triangle({16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0});
        send_triangle({16'd2, 16'd2, 16'd2, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0});
        send_triangle({16'd3, 16'd0, 16'd0, 16'd0, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0});
        send_triangle({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0});
        send_triangle({m, m, 16'd0, p, m, 16'd0, m, p, 16'd0});
        send_triangle({16'hffff, 16'h5555, 16'haaaa, 16'h0001, 16'haaaa,
                       16'h5555, 16'h8001, 16'h7ffe, 16'h0000});
        send_triangle({16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
                       16'h1234, 16'h0000, 16'h0000, 16'h0001});
        drain();

        send_random(200);
        idle_pct = 46;
        send_random(200);
        drain();
        idle_pct = 6;
        send_random(150);
        idle_pct = 0;
        send_random(200);
        drain();

        $display("covered %0d triangles, %0d of them degenerate, with input gaps",
                 normals_seen, degenerate_seen);
        if (fail_count == 0)
            $display("triangle_face_normal_top regression: pass");
        else
            $display("triangle_face_normal_top regression: fail");
        $finish;
    end

endmodule

@@ triangle_face_normal_top.f @@
hdl/tfn_pkg.sv
hdl/tfn_step.sv
hdl/triangle_face_normal_top.sv
sim/triangle_face_normal_checker.sv
sim/tb_triangle_face_normal_top.sv
